// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/tsd_pkg.sv =====
// ----------------------------------------------------------------------------
// tsd_pkg
// Constants, codes and types shared by the trace sample decider.
// ----------------------------------------------------------------------------
package tsd_pkg;

    // Command time table
    localparam int CMD_SLOTS = 1024;
    localparam int CMD_AW    = $clog2(CMD_SLOTS);
    localparam int TIME_W    = 32;

    // Field widths
    localparam int UID_W      = 32;
    localparam int CMD_W      = 10;
    localparam int RATIO_W    = 14;
    localparam int INTERVAL_W = 16;
    localparam int CFG_IW     = 3;
    localparam int CFG_DW     = 32;

    localparam logic [RATIO_W-1:0] FULL_RATIO = RATIO_W'(10000);

    // Allow list
    localparam int NUM_ALLOW = 6;
    localparam int ALLOW_IW  = $clog2(NUM_ALLOW);

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_SAMPLE_RATIO   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_FLOOR_INTERVAL = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_ALLOW_UID_0    = 3'd2;

    // Decision reason codes
    typedef enum logic [2:0] {
        WHY_NOT_ROOT   = 3'd0,
        WHY_RATIO_ZERO = 3'd1,
        WHY_RATIO_FULL = 3'd2,
        WHY_ALLOW_LIST = 3'd3,
        WHY_RANDOM     = 3'd4,
        WHY_FLOOR      = 3'd5,
        WHY_DROPPED    = 3'd6
    } why_t;

endpackage

// ===== rtl/trace_sample_decider.sv =====
// ----------------------------------------------------------------------------
// trace_sample_decider
// Per-request trace sampling decision with allow list and per-command floor.
// ----------------------------------------------------------------------------
// Takes one request per clock while the output is not stalled, and returns
// one keep/why result per request, registered in stage one and then in the
// output register. The rate is set by the per-command time table: each request
// reads its entry when accepted; one kept by allow list, draw or floor with a
// valid command stamps its time as it leaves stage one, and a back-to-back
// request to the same command picks up the fresh time through a forwarding
// register. After reset the table is swept to zero, one entry per cycle, over
// all CMD_SLOTS (1024) entries; in_ready stays low during the sweep while
// configuration writes are taken as usual. cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trace_sample_decider
    import tsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [UID_W-1:0]      user_id,
    input  logic [CMD_W-1:0]      command_id,
    input  logic                  is_root,
    input  logic [TIME_W-1:0]     now_seconds,
    input  logic [RATIO_W-1:0]    random_draw,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  keep,
    output logic [2:0]            why,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IW-1:0]     cfg_index,
    input  logic [CFG_DW-1:0]     cfg_data
);

    // Configuration registers
    logic [RATIO_W-1:0]    ratio_reg;
    logic [INTERVAL_W-1:0] interval_reg;
    logic [UID_W-1:0]      allow_reg [NUM_ALLOW];

    // Clearing sweep
    logic                  clear_reg, clear_next;
    logic [CMD_AW-1:0]     clr_addr_reg, clr_addr_next;

    // Stage one: request waiting on table read data
    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_root_reg;
    logic                  s1_zero_reg;
    logic                  s1_full_reg;
    logic                  s1_allow_reg;
    logic                  s1_draw_reg;
    logic                  s1_cmd_ok_reg;
    logic [CMD_AW-1:0]     s1_addr_reg;
    logic [TIME_W-1:0]     s1_now_reg;
    logic                  s1_fwd_reg;
    logic [TIME_W-1:0]     s1_fwd_time_reg;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic                  keep_reg;
    why_t                  why_reg;

    // Datapath signals
    logic                  accept;
    logic                  s1_adv;
    logic                  allow_hit;
    logic                  cmd_ok;
    logic [CMD_AW-1:0]     rd_addr;
    logic [TIME_W-1:0]     ram_rdata;
    logic [TIME_W-1:0]     last_time;
    logic                  floor_hit;
    logic                  dec_keep;
    why_t                  dec_why;
    logic                  stamp_we;
    logic                  ram_we;
    logic [CMD_AW-1:0]     ram_waddr;
    logic [TIME_W-1:0]     ram_wdata;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !clear_reg && (!s1_valid_reg || s1_adv);
    assign accept    = in_valid && in_ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg    <= FULL_RATIO;
            interval_reg <= INTERVAL_W'(300);
            for (int i = 0; i < NUM_ALLOW; i++)
            begin
                allow_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SAMPLE_RATIO:   ratio_reg    <= cfg_data[RATIO_W-1:0];
                CFG_FLOOR_INTERVAL: interval_reg <= cfg_data[INTERVAL_W-1:0];
                default:
                begin
                    allow_reg[ALLOW_IW'(cfg_index - CFG_ALLOW_UID_0)] <= cfg_data[UID_W-1:0];
                end
            endcase
        end
    end

    // Request side: allow list match and command check
    always_comb
    begin
        allow_hit = 1'b0;
        for (int i = 0; i < NUM_ALLOW; i++)
        begin
            if (allow_reg[i] == user_id)
            begin
                allow_hit = 1'b1;
            end
        end
        allow_hit = allow_hit && (user_id != '0);
    end

    assign cmd_ok  = (command_id != '0) && (32'(command_id) < 32'(CMD_SLOTS));
    assign rd_addr = CMD_AW'(command_id);

    // Clearing sweep control
    always_comb
    begin
        clear_next    = clear_reg;
        clr_addr_next = clr_addr_reg;
        if (clear_reg)
        begin
            if (clr_addr_reg == CMD_AW'(CMD_SLOTS - 1))
            begin
                clear_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clear_reg    <= clear_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Stage one capture; ratio, allow and draw tests are settled here
    assign s1_valid_next = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_root_reg     <= is_root;
            s1_zero_reg     <= (ratio_reg == '0);
            s1_full_reg     <= (ratio_reg >= FULL_RATIO);
            s1_allow_reg    <= allow_hit;
            // ratio above full never reaches the draw test
            s1_draw_reg     <= (random_draw < ratio_reg);
            s1_cmd_ok_reg   <= cmd_ok;
            s1_addr_reg     <= rd_addr;
            s1_now_reg      <= now_seconds;
            // RAM returns old data when the write back hits the same entry
            s1_fwd_reg      <= stamp_we && (ram_waddr == rd_addr);
            s1_fwd_time_reg <= s1_now_reg;
        end
    end

    // Stage one decision
    assign last_time = s1_fwd_reg ? s1_fwd_time_reg : ram_rdata;
    assign floor_hit = s1_cmd_ok_reg &&
                       ({1'b0, s1_now_reg} > ({1'b0, last_time} + (TIME_W + 1)'(interval_reg)));

    always_comb
    begin
        dec_keep = 1'b1;
        dec_why  = WHY_DROPPED;
        if (!s1_root_reg)
        begin
            dec_keep = 1'b0;
            dec_why  = WHY_NOT_ROOT;
        end
        else if (s1_zero_reg)
        begin
            dec_keep = 1'b0;
            dec_why  = WHY_RATIO_ZERO;
        end
        else if (s1_full_reg)
        begin
            dec_why = WHY_RATIO_FULL;
        end
        else if (s1_allow_reg)
        begin
            dec_why = WHY_ALLOW_LIST;
        end
        else if (s1_draw_reg)
        begin
            dec_why = WHY_RANDOM;
        end
        else if (floor_hit)
        begin
            dec_why = WHY_FLOOR;
        end
        else
        begin
            dec_keep = 1'b0;
            dec_why  = WHY_DROPPED;
        end
    end

    // Time stamp write back; a full ratio keep leaves the table alone
    assign stamp_we = s1_adv && s1_cmd_ok_reg &&
                      ((dec_why == WHY_ALLOW_LIST) || (dec_why == WHY_RANDOM) ||
                       (dec_why == WHY_FLOOR));

    assign ram_we    = clear_reg || stamp_we;
    assign ram_waddr = clear_reg ? clr_addr_reg : s1_addr_reg;
    assign ram_wdata = clear_reg ? '0 : s1_now_reg;

    tsd_ram #(
        .WIDTH (TIME_W),
        .DEPTH (CMD_SLOTS)
    ) u_time_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Output register
    assign out_valid_next = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            keep_reg <= dec_keep;
            why_reg  <= dec_why;
        end
    end

    assign out_valid = out_valid_reg;
    assign keep      = keep_reg;
    assign why       = why_reg;

    // Assertions
    `ASSERT_NEVER(a_no_stamp_in_clear, clear_reg && stamp_we,
        "time stamp written during clearing sweep")
    `ASSERT_CLK(a_stamp_valid_cmd, stamp_we |-> s1_cmd_ok_reg && s1_root_reg,
        "time stamp for invalid command or non-root request")
    `ASSERT_CLK(a_s1_holds_on_stall,
        (s1_valid_reg && out_valid_reg && !out_ready) |=> s1_valid_reg,
        "pending request lost while output stalled")
    `ASSERT_CLK(a_keep_matches_why,
        out_valid_reg |-> (keep_reg == ((why_reg == WHY_RATIO_FULL) ||
            (why_reg == WHY_ALLOW_LIST) || (why_reg == WHY_RANDOM) ||
            (why_reg == WHY_FLOOR))),
        "keep flag disagrees with reason code")

endmodule

// ===== rtl/tsd_ram.sv =====
// ----------------------------------------------------------------------------
// tsd_ram
// Generic single write, single read RAM with a registered read port.
// A read and write of the same address in one cycle returns the old data.
// ----------------------------------------------------------------------------
module tsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
